### rtl/f2d96_pkg.sv
// f2d96_pkg: shared types and constants of the binary32 to decimal96 converter
// used by f2d96_ctrl, f2d96_datapath and float_to_decimal96_convert
`timescale 1ns / 1ps

package f2d96_pkg;

   localparam int WIDE_W    = 146;
   localparam int Q_W       = 25;
   localparam int CNT_W     = 6;
   localparam int K_W       = 7;
   localparam int COEF_W    = 96;
   localparam int SCALE_W   = 5;
   localparam int SHAMT_W   = 5;
   localparam int PROD_W    = 22;

   localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
   localparam logic [30:0] MAG_MAX      = 31'h6F80_0000;
   localparam logic [30:0] MAG_MIN      = 31'h10FD_87B6;
   localparam int          EXP_BIAS     = 127;
   localparam int          MANT_OFFSET  = 150;
   localparam int          LOG2_NUM     = 1233;
   localparam int          LOG2_SHIFT   = 12;
   localparam int          DIGITS_M1    = 6;
   localparam int          TEN6         = 1000000;
   localparam int          TEN7         = 10000000;
   localparam int          SCALE_MAX    = 28;
   localparam int          ZERO_SCALE   = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DSTART,
      ST_DIV,
      ST_CHECK,
      ST_RETRY,
      ST_ROUND,
      ST_POST,
      ST_PMUL,
      ST_PSCALE,
      ST_PDSTART,
      ST_PDIV,
      ST_FINISH,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL,
      CMD_DSTART,
      CMD_DIV,
      CMD_RETRY,
      CMD_ROUND,
      CMD_POST,
      CMD_FINISH
   } dp_cmd_type;

   typedef struct packed {
      logic special;
      logic cnt_zero;
      logic q_big;
      logic k_pos;
      logic s_over;
   } dp_status_type;

endpackage

### rtl/f2d96_ctrl.sv
// f2d96_ctrl: sequencing state machine of the converter
// depends on f2d96_pkg
`timescale 1ns / 1ps

module f2d96_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  f2d96_pkg::dp_status_type status,
   output f2d96_pkg::dp_cmd_type   cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import f2d96_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (status.special) state_in = ST_DONE;
            else if (status.cnt_zero) state_in = ST_DSTART;
         end
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (status.cnt_zero) state_in = ST_CHECK;
         end
         ST_CHECK: state_in = status.q_big ? ST_RETRY : ST_ROUND;
         ST_RETRY: state_in = ST_DSTART;
         ST_ROUND: state_in = ST_POST;
         ST_POST: begin
            if (status.k_pos) state_in = ST_PMUL;
            else if (status.s_over) state_in = ST_PSCALE;
            else state_in = ST_DONE;
         end
         ST_PMUL: begin
            if (status.cnt_zero) state_in = ST_FINISH;
         end
         ST_PSCALE: begin
            if (status.cnt_zero) state_in = ST_PDSTART;
         end
         ST_PDSTART: state_in = ST_PDIV;
         ST_PDIV: begin
            if (status.cnt_zero) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = CMD_NONE;
      unique case (state_ff)
         ST_IDLE:    cmd = start ? CMD_LOAD : CMD_NONE;
         ST_SCALE:   cmd = (!status.special && !status.cnt_zero) ? CMD_MUL : CMD_NONE;
         ST_DSTART:  cmd = CMD_DSTART;
         ST_PDSTART: cmd = CMD_DSTART;
         ST_DIV:     cmd = CMD_DIV;
         ST_PDIV:    cmd = CMD_DIV;
         ST_RETRY:   cmd = CMD_RETRY;
         ST_ROUND:   cmd = CMD_ROUND;
         ST_POST:    cmd = CMD_POST;
         ST_PMUL:    cmd = status.cnt_zero ? CMD_NONE : CMD_MUL;
         ST_PSCALE:  cmd = status.cnt_zero ? CMD_NONE : CMD_MUL;
         ST_FINISH:  cmd = CMD_FINISH;
         default:    cmd = CMD_NONE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

### rtl/f2d96_datapath.sv
// f2d96_datapath: wide scaling registers, times-ten unit, restoring divider
// and rounding of the converter; depends on f2d96_pkg
`timescale 1ns / 1ps

module f2d96_datapath (
   input  logic                      clock,
   input  f2d96_pkg::dp_cmd_type     cmd,
   input  logic [31:0]               req_float_bits,
   output f2d96_pkg::dp_status_type  status,
   output logic                      rsp_error,
   output logic                      rsp_negative,
   output logic [4:0]                rsp_scale,
   output logic [31:0]               rsp_coef_word0,
   output logic [31:0]               rsp_coef_word1,
   output logic [31:0]               rsp_coef_word2
);
   import f2d96_pkg::*;

   logic [WIDE_W-1:0]   x_ff, x_in, y_ff, y_in, xs_ff, xs_in;
   logic [Q_W-1:0]      q_ff, q_in;
   logic signed [K_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                mul_y_ff, mul_y_in;
   logic                special_ff, special_in;
   logic                err_ff, err_in;
   logic                neg_ff, neg_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [COEF_W-1:0]   coef_ff, coef_in;

   logic [7:0]              exp_f;
   logic [30:0]             mag;
   logic [WIDE_W-1:0]       mant_w;
   logic signed [8:0]       e_s;
   logic signed [8:0]       p_s;
   logic signed [PROD_W-1:0] prod_s;
   logic signed [PROD_W-1:0] est_s;
   logic signed [K_W-1:0]   k_load;
   logic [6:0]              shamt;
   logic [WIDE_W-1:0]       mul_src, mul_res;
   logic [WIDE_W-1:0]       trial;
   logic                    ge;
   logic [WIDE_W:0]         twice_rem, den_ext;
   logic                    round_up;
   logic [Q_W-1:0]          q_round;
   logic signed [K_W-1:0]   k_neg;

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      xs_ff      <= xs_in;
      q_ff       <= q_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      mul_y_ff   <= mul_y_in;
      special_ff <= special_in;
      err_ff     <= err_in;
      neg_ff     <= neg_in;
      scale_ff   <= scale_in;
      coef_ff    <= coef_in;
   end

   always_comb begin
      exp_f   = req_float_bits[30:23];
      mag     = req_float_bits[30:0];
      mant_w  = WIDE_W'({1'b1, req_float_bits[22:0]});
      e_s     = $signed({1'b0, exp_f}) - 9'sd150;
      p_s     = $signed({1'b0, exp_f}) - 9'(EXP_BIAS);
      prod_s  = PROD_W'(p_s) * PROD_W'(LOG2_NUM);
      est_s   = prod_s >>> LOG2_SHIFT;
      k_load  = K_W'(est_s) - K_W'(DIGITS_M1);
      shamt   = (e_s > 9'sd0) ? 7'(e_s) : 7'(-e_s);
      mul_src = mul_y_ff ? y_ff : x_ff;
      mul_res = (mul_src << 3) + (mul_src << 1);
      trial   = y_ff << cnt_ff[SHAMT_W-1:0];
      ge      = (x_ff >= trial);
      twice_rem = {x_ff, 1'b0};
      den_ext   = {1'b0, y_ff};
      round_up  = (twice_rem > den_ext) || ((twice_rem == den_ext) && q_ff[0]);
      q_round   = q_ff + Q_W'(round_up);
      k_neg     = -k_ff;
   end

   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      xs_in      = xs_ff;
      q_in       = q_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      mul_y_in   = mul_y_ff;
      special_in = special_ff;
      err_in     = err_ff;
      neg_in     = neg_ff;
      scale_in   = scale_ff;
      coef_in    = coef_ff;
      unique case (cmd)
         CMD_NONE: begin
         end
         CMD_LOAD: begin
            err_in     = 1'b0;
            neg_in     = 1'b0;
            scale_in   = '0;
            coef_in    = '0;
            special_in = 1'b0;
            if ((exp_f == EXP_ALL_ONES) || (mag > MAG_MAX) ||
                ((mag != '0) && (mag < MAG_MIN))) begin
               err_in     = 1'b1;
               special_in = 1'b1;
            end else if (mag == '0) begin
               scale_in   = SCALE_W'(ZERO_SCALE);
               special_in = 1'b1;
            end else begin
               neg_in = req_float_bits[31];
            end
            if (e_s > 9'sd0) begin
               x_in = mant_w << shamt;
               y_in = WIDE_W'(1);
            end else begin
               x_in = mant_w;
               y_in = WIDE_W'(1) << shamt;
            end
            xs_in    = x_in;
            k_in     = k_load;
            cnt_in   = (k_load < 0) ? CNT_W'(-k_load) : CNT_W'(k_load);
            mul_y_in = (k_load > 0);
         end
         CMD_MUL: begin
            if (mul_y_ff) begin
               y_in = mul_res;
            end else begin
               x_in  = mul_res;
               xs_in = mul_res;
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         CMD_DSTART: begin
            q_in   = '0;
            cnt_in = CNT_W'(Q_W - 1);
         end
         CMD_DIV: begin
            if (ge) begin
               x_in = x_ff - trial;
               q_in = q_ff | (Q_W'(1) << cnt_ff[SHAMT_W-1:0]);
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         CMD_RETRY: begin
            x_in = xs_ff;
            y_in = (y_ff << 3) + (y_ff << 1);
            k_in = k_ff + K_W'(1);
         end
         CMD_ROUND: begin
            if (q_round == Q_W'(TEN7)) begin
               q_in = Q_W'(TEN6);
               k_in = k_ff + K_W'(1);
            end else begin
               q_in = q_round;
            end
         end
         CMD_POST: begin
            if (k_ff > 0) begin
               x_in     = WIDE_W'(q_ff);
               cnt_in   = CNT_W'(k_ff);
               mul_y_in = 1'b0;
            end else if (k_ff < -K_W'(SCALE_MAX)) begin
               x_in     = WIDE_W'(q_ff);
               y_in     = WIDE_W'(1);
               cnt_in   = CNT_W'(k_neg - K_W'(SCALE_MAX));
               mul_y_in = 1'b1;
            end else begin
               coef_in  = COEF_W'(q_ff);
               scale_in = SCALE_W'(k_neg);
            end
         end
         CMD_FINISH: begin
            if (k_ff > 0) begin
               coef_in  = x_ff[COEF_W-1:0];
               scale_in = '0;
            end else begin
               coef_in  = COEF_W'(q_ff);
               scale_in = SCALE_W'(SCALE_MAX);
            end
         end
         default: begin
         end
      endcase
   end

   assign status.special  = special_ff;
   assign status.cnt_zero = (cnt_ff == '0);
   assign status.q_big    = (q_ff >= Q_W'(TEN7));
   assign status.k_pos    = (k_ff > 0);
   assign status.s_over   = (k_ff < -K_W'(SCALE_MAX));

   assign rsp_error      = err_ff;
   assign rsp_negative   = neg_ff;
   assign rsp_scale      = scale_ff;
   assign rsp_coef_word0 = coef_ff[31:0];
   assign rsp_coef_word1 = coef_ff[63:32];
   assign rsp_coef_word2 = coef_ff[95:64];

endmodule

### rtl/float_to_decimal96_convert.sv
// float_to_decimal96_convert: binary32 to decimal96 converter top level
// depends on f2d96_pkg, f2d96_ctrl, f2d96_datapath
//
//  channel   ports                              handshake
//  request   req_float_bits                     start high while busy low
//  response  rsp_error, rsp_negative,           rsp_valid high for one cycle
//            rsp_scale, rsp_coef_word0..2
//
// one item at a time; nan, infinity, out-of-range and zero go from the scale
// state straight to done; other inputs run the times-ten loop (one step a
// cycle), the 25-bit restoring division and its retry when the digit
// estimate is one low, and the final scaling loop on the 146-bit registers
// synchronous reset returns the controller to idle; the receiver cannot stall
`timescale 1ns / 1ps

module float_to_decimal96_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_float_bits,
   output logic        rsp_valid,
   output logic        rsp_error,
   output logic        rsp_negative,
   output logic [4:0]  rsp_scale,
   output logic [31:0] rsp_coef_word0,
   output logic [31:0] rsp_coef_word1,
   output logic [31:0] rsp_coef_word2
);
   import f2d96_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   f2d96_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   f2d96_datapath u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .req_float_bits (req_float_bits),
      .status         (status),
      .rsp_error      (rsp_error),
      .rsp_negative   (rsp_negative),
      .rsp_scale      (rsp_scale),
      .rsp_coef_word0 (rsp_coef_word0),
      .rsp_coef_word1 (rsp_coef_word1),
      .rsp_coef_word2 (rsp_coef_word2)
   );

endmodule
